// ----- hw/rtl/spwm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and functions of the three-phase sine PWM commutator.
package spwm_pkg;

    // Field and register widths
    localparam int POS_W       = 13;
    localparam int AMP_W       = 15;
    localparam int PERIOD_W    = 16;
    localparam int PWM_W       = 16;
    localparam int MASK_W      = 3;
    localparam int SECTOR_W    = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MAG_W       = 15;

    // Default circle resolution: microphases per sector = 2^SECTOR_BITS
    localparam int SECTOR_BITS_DEF = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD = 1'd1;

    // Configuration reset values
    localparam logic [AMP_W-1:0]    AMP_RESET    = 15'd32767;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Phase codes (winding A, B at +120 deg, C at +240 deg)
    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_C = 2'd2;

    // Divide by six as multiply by ceil(2^18/6) then shift; exact below 2^17
    localparam int             RECIP_W    = 16;
    localparam logic [15:0]    RECIP_SIX  = 16'd43691;
    localparam int             DIV_SHIFT  = 18;

    // Gain is reduced by this bias before scaling the sine magnitude
    localparam logic [PWM_W-1:0] GAIN_BIAS = 16'd2;

    // Constants for building the quarter-wave sine ROM
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q15_FULL    = 64'd32767;
    localparam longint unsigned TAYLOR_DIV [12] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    // Command group from controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       issue;
        logic [1:0] issue_phase;
        logic       load_out;
    } spwm_cmd_t;

    // Value modulo six for a 5-bit value, three compare-subtract steps
    function automatic logic [SECTOR_W-1:0] mod_six(input logic [4:0] value);
        logic [4:0] v;
        v = value;
        if (v >= 5'd24)
        begin
            v = v - 5'd24;
        end
        if (v >= 5'd12)
        begin
            v = v - 5'd12;
        end
        if (v >= 5'd6)
        begin
            v = v - 5'd6;
        end
        return v[SECTOR_W-1:0];
    endfunction

    // Positive-drive mask per sector: AB, A, AC, C, BC, B
    function automatic logic [MASK_W-1:0] sector_mask(input logic [SECTOR_W-1:0] sector);
        logic [MASK_W-1:0] m;
        case (sector)
            3'd0:    m = 3'b011;
            3'd1:    m = 3'b001;
            3'd2:    m = 3'b101;
            3'd3:    m = 3'b100;
            3'd4:    m = 3'b110;
            3'd5:    m = 3'b010;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    // Rounded 32767*sin(r*pi/2 / 2^qbits), Q30 Taylor series, elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(r) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * Q15_FULL + (64'd1 << 29)) >> 30;
        return v[MAG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/three_phase_sine_pwm_commutator.sv -----
`timescale 1ns / 1ps
// Top level of the three-phase sinusoidal PWM commutator.
//
// Usage: an item on the input channel (in_valid/in_ready, field position) is a
// rotor microphase. The result item on the output channel (out_valid/out_ready)
// holds the three winding pulse widths, the positive-drive mask, the sector and
// a flag set when the sector differs from the previous item's sector.
// Registers amplitude (index 0) and pwm_period (index 1) are written through
// cfg_write/cfg_index/cfg_data while no item is in flight.
// An accepted item is registered and its three phases pass the pipe; a new item
// is accepted only once the result has left the datapath. The three phases share one
// divide-by-six multiplier, one quarter-wave sine ROM port and one scaling
// multiplier, issued one phase per cycle through a three-stage pipe.
// A finished result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following result waits in the datapath
// and no further item is accepted until the output register is free.
// Reset: no result pending, amplitude = 32767, pwm_period = 1000, last sector 0.
module three_phase_sine_pwm_commutator
    import spwm_pkg::*;
#(
    parameter int SECTOR_BITS_P = SECTOR_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [POS_W-1:0]       position,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PWM_W-1:0]       width_a,
    output logic [PWM_W-1:0]       width_b,
    output logic [PWM_W-1:0]       width_c,
    output logic [MASK_W-1:0]      drive_positive,
    output logic                   sector_changed,
    output logic [SECTOR_W-1:0]    sector,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    spwm_cmd_t cmd;

    // Sequencing and handshakes
    spwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Arithmetic, ROM and result registers
    spwm_datapath #(
        .SECTOR_BITS (SECTOR_BITS_P)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .position       (position),
        .width_a        (width_a),
        .width_b        (width_b),
        .width_c        (width_c),
        .drive_positive (drive_positive),
        .sector_changed (sector_changed),
        .sector         (sector)
    );

endmodule

// ----- hw/rtl/spwm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the sine PWM commutator: sequencing and handshakes.
module spwm_ctrl
    import spwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output spwm_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Phases are issued on steps 0..2; the last product lands on step 4
    localparam logic [2:0] ISSUE_STEPS = 3'd3;
    localparam logic [2:0] LAST_STEP   = 3'd4;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cmd             = '0;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    step_next     = 3'd0;
                    state_next    = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (step_reg < ISSUE_STEPS)
                begin
                    cmd.issue       = 1'b1;
                    cmd.issue_phase = step_reg[1:0];
                end
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/spwm_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sine PWM commutator: config, gain, angle divide, sine ROM, scaling.
module spwm_datapath
    import spwm_pkg::*;
#(
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  spwm_cmd_t              cmd,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [POS_W-1:0]       position,
    output logic [PWM_W-1:0]       width_a,
    output logic [PWM_W-1:0]       width_b,
    output logic [PWM_W-1:0]       width_c,
    output logic [MASK_W-1:0]      drive_positive,
    output logic                   sector_changed,
    output logic [SECTOR_W-1:0]    sector
);

    localparam int QBITS   = SECTOR_BITS - 2;
    localparam int QDEPTH  = (1 << QBITS) + 1;
    localparam int ADDR_W  = SECTOR_BITS - 1;
    localparam int RPOS_W  = SECTOR_BITS + SECTOR_W;
    localparam int SUM_W   = SECTOR_BITS + 4;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int GPROD_W = AMP_W + PERIOD_W;
    localparam int WPROD_W = MAG_W + PWM_W;
    localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(1 << QBITS);

    // Quarter-wave magnitude ROM, entries 0..quarter inclusive
    typedef logic [MAG_W-1:0] rom_t [QDEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < QDEPTH; i++)
        begin
            t[i] = quarter_sine(i, QBITS);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [AMP_W-1:0]    amplitude_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PWM_W-1:0]    gain_reg;
    logic [PWM_W-1:0]    gain_m2_reg;
    logic                gain_ok_reg;

    logic [RPOS_W-1:0]   pos_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic                changed_reg;
    logic [SECTOR_W-1:0] last_sector_reg;

    logic                s1_valid_reg;
    logic [1:0]          s1_phase_reg;
    logic [SECTOR_BITS-1:0] s1_idx_reg;
    logic                s2_valid_reg;
    logic [1:0]          s2_phase_reg;
    logic [MAG_W-1:0]    s2_mag_reg;

    logic [PWM_W-1:0]    work_a_reg;
    logic [PWM_W-1:0]    work_b_reg;
    logic [PWM_W-1:0]    work_c_reg;

    logic [PWM_W-1:0]    width_a_reg;
    logic [PWM_W-1:0]    width_b_reg;
    logic [PWM_W-1:0]    width_c_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                changed_out_reg;
    logic [SECTOR_W-1:0] sector_out_reg;

    logic [SECTOR_W-1:0] in_sector;
    logic [GPROD_W-1:0]  gain_prod;
    logic [SUM_W-1:0]    angle_sum;
    logic [PROD_W-1:0]   angle_prod;
    logic [QBITS-1:0]    fold_r;
    logic [ADDR_W-1:0]   rom_addr;
    logic [WPROD_W-1:0]  width_prod;
    logic [PWM_W-1:0]    width_val;

    assign width_a        = width_a_reg;
    assign width_b        = width_b_reg;
    assign width_c        = width_c_reg;
    assign drive_positive = mask_reg;
    assign sector_changed = changed_out_reg;
    assign sector         = sector_out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= AMP_RESET;
            period_reg    <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_AMPLITUDE)
            begin
                amplitude_reg <= cfg_data[AMP_W-1:0];
            end
            if (cfg_index == CFG_PWM_PERIOD)
            begin
                period_reg <= cfg_data[PERIOD_W-1:0];
            end
        end
    end

    // Gain = amplitude * period >> 15, then bias removed; follows config
    assign gain_prod = GPROD_W'(amplitude_reg) * GPROD_W'(period_reg);

    always_ff @(posedge clk)
    begin
        gain_reg    <= gain_prod[GPROD_W-1:GPROD_W-PWM_W];
        gain_m2_reg <= gain_reg - GAIN_BIAS;
        gain_ok_reg <= (gain_reg >= GAIN_BIAS);
    end

    // Sector of the item: position reduced modulo six sectors
    assign in_sector = mod_six(5'(position >> SECTOR_BITS));

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pos_reg     <= {in_sector, position[SECTOR_BITS-1:0]};
            sector_reg  <= in_sector;
            changed_reg <= (in_sector != last_sector_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sector_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            last_sector_reg <= in_sector;
        end
    end

    // Stage 1: angle = (position + phase * 2 sectors) / 6 mod circle
    assign angle_sum  = SUM_W'(pos_reg)
                      + SUM_W'({cmd.issue_phase, {(SECTOR_BITS+1){1'b0}}});
    assign angle_prod = PROD_W'(angle_sum) * PROD_W'(RECIP_SIX);

    always_ff @(posedge clk)
    begin
        s1_phase_reg <= cmd.issue_phase;
        s1_idx_reg   <= angle_prod[DIV_SHIFT +: SECTOR_BITS];
    end

    // Stage 2: fold the angle into the quarter wave and read the ROM
    assign fold_r   = s1_idx_reg[QBITS-1:0];
    assign rom_addr = s1_idx_reg[QBITS] ? (QUARTER - ADDR_W'(fold_r)) : ADDR_W'(fold_r);

    always_ff @(posedge clk)
    begin
        s2_phase_reg <= s1_phase_reg;
        s2_mag_reg   <= SINE_ROM[rom_addr];
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 3: scale the magnitude by the biased gain
    assign width_prod = WPROD_W'(s2_mag_reg) * WPROD_W'(gain_m2_reg);
    assign width_val  = gain_ok_reg ? width_prod[WPROD_W-1:WPROD_W-PWM_W] : '0;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            case (s2_phase_reg)
                PHASE_A: work_a_reg <= width_val;
                PHASE_B: work_b_reg <= width_val;
                PHASE_C: work_c_reg <= width_val;
                default:
                begin
                end
            endcase
        end
    end

    // Output register, loaded when the result slot is free
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            width_a_reg     <= work_a_reg;
            width_b_reg     <= work_b_reg;
            width_c_reg     <= work_c_reg;
            mask_reg        <= sector_mask(sector_reg);
            changed_out_reg <= changed_reg;
            sector_out_reg  <= sector_reg;
        end
    end

endmodule

// ----- dv/three_phase_sine_pwm_commutator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the sine PWM commutator: directed table, then random positions.
module three_phase_sine_pwm_commutator_tb
    import spwm_pkg::*;
();

    localparam int SECTOR_BITS      = SECTOR_BITS_DEF;
    localparam int SECTOR_SPAN      = 1 << SECTOR_BITS;
    localparam int CIRCLE_SPAN      = 6 * SECTOR_SPAN;
    localparam int QUARTER_SPAN     = SECTOR_SPAN / 4;
    localparam int GAIN_PHASES      = 10;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int SETTLE_CYCLES    = 10;

    // Traffic modes: who idles and how often
    localparam int MODE_SLOW_SINK   = 0;
    localparam int MODE_SLOW_SOURCE = 1;
    localparam int MODE_FULL_RATE   = 2;

    typedef struct packed {
        logic [PWM_W-1:0]    width_a;
        logic [PWM_W-1:0]    width_b;
        logic [PWM_W-1:0]    width_c;
        logic [MASK_W-1:0]   drive_positive;
        logic                sector_changed;
        logic [SECTOR_W-1:0] sector;
    } pwm_frame_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic                pinned;
        logic [SECTOR_W-1:0] sec;
        logic [MASK_W-1:0]   mask;
        logic                chg;
    } directed_row_t;

    // Positive-drive windings per sector: AB, A, AC, C, BC, B
    localparam logic [MASK_W-1:0] DRIVE_MASK [6] =
        '{3'b011, 3'b001, 3'b101, 3'b100, 3'b110, 3'b010};

    // Directed positions; pinned rows carry sector, mask and change flag by hand
    localparam directed_row_t DIRECTED [22] = '{
        '{13'd0,    1'b1, 3'd0, 3'b011, 1'b0},  // first item after reset, same sector
        '{13'd1023, 1'b1, 3'd0, 3'b011, 1'b0},
        '{13'd1024, 1'b1, 3'd1, 3'b001, 1'b1},
        '{13'd2047, 1'b1, 3'd1, 3'b001, 1'b0},
        '{13'd2048, 1'b1, 3'd2, 3'b101, 1'b1},
        '{13'd3072, 1'b1, 3'd3, 3'b100, 1'b1},
        '{13'd4096, 1'b1, 3'd4, 3'b110, 1'b1},
        '{13'd5120, 1'b1, 3'd5, 3'b010, 1'b1},
        '{13'd6143, 1'b1, 3'd5, 3'b010, 1'b0},  // top of the circle
        '{13'd6144, 1'b1, 3'd0, 3'b011, 1'b1},  // out of range, wraps to 0
        '{13'd8191, 1'b1, 3'd1, 3'b001, 1'b1},  // all ones, wraps to 2047
        '{13'd7168, 1'b1, 3'd1, 3'b001, 1'b0},  // wraps into the same sector
        '{13'd256,  1'b1, 3'd0, 3'b011, 1'b1},
        '{13'd512,  1'b1, 3'd0, 3'b011, 1'b0},
        '{13'd768,  1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd5,    1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd3583, 1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd4607, 1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd6000, 1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd1,    1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd4095, 1'b0, 3'd0, 3'b000, 1'b0},
        '{13'd6142, 1'b0, 3'd0, 3'b000, 1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [POS_W-1:0]       position = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [PWM_W-1:0]       width_a;
    logic [PWM_W-1:0]       width_b;
    logic [PWM_W-1:0]       width_c;
    logic [MASK_W-1:0]      drive_positive;
    logic                   sector_changed;
    logic [SECTOR_W-1:0]    sector;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_AMPLITUDE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: register shadows, last sector, sine magnitudes
    int unsigned amp_reg;
    int unsigned period_reg;
    int unsigned prev_sector;
    int unsigned sine_mag [SECTOR_SPAN];
    int unsigned walk_pos;

    pwm_frame_t  pending_frames [$];
    int          traffic_mode = MODE_SLOW_SINK;
    int unsigned items_sent;
    int unsigned frames_checked;
    int unsigned sector_changes;
    int unsigned mismatch_count;

    three_phase_sine_pwm_commutator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .width_a        (width_a),
        .width_b        (width_b),
        .width_c        (width_c),
        .drive_positive (drive_positive),
        .sector_changed (sector_changed),
        .sector         (sector),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Rounded 32767*sin(r/QUARTER_SPAN * pi/2), Q30 Taylor series
    function automatic int unsigned quarter_wave(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x    = r;
        x    = (x * HALF_PI_Q30) / QUARTER_SPAN;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * x2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return int'((sum * Q15_FULL + (64'd1 << 29)) >> 30);
    endfunction

    // One winding's pulse width: |sin| scaled by the biased gain
    function automatic logic [PWM_W-1:0] phase_width(input int unsigned pos,
                                                     input int unsigned offset,
                                                     input int unsigned gain);
        int unsigned idx;
        int unsigned prod;
        idx = ((pos + offset) / 6) % SECTOR_SPAN;
        if (gain < 2)
        begin
            return '0;
        end
        prod = sine_mag[idx] * (gain - 2);
        return PWM_W'(prod >> 15);
    endfunction

    // Expected frame for one position; advances the last-sector shadow
    function automatic pwm_frame_t commutate(input logic [POS_W-1:0] p);
        pwm_frame_t  f;
        int unsigned pos;
        int unsigned sec;
        int unsigned gain;
        pos              = p % CIRCLE_SPAN;
        sec              = pos >> SECTOR_BITS;
        gain             = (amp_reg * period_reg) >> 15;
        f.width_a        = phase_width(pos, 0, gain);
        f.width_b        = phase_width(pos, 2 * SECTOR_SPAN, gain);
        f.width_c        = phase_width(pos, 4 * SECTOR_SPAN, gain);
        f.drive_positive = DRIVE_MASK[sec];
        f.sector_changed = (sec != prev_sector);
        f.sector         = SECTOR_W'(sec);
        if (f.sector_changed)
        begin
            sector_changes++;
        end
        prev_sector = sec;
        return f;
    endfunction

    function automatic bit sender_pauses();
        case (traffic_mode)
            MODE_SLOW_SINK:   return $urandom_range(99) < 28;
            MODE_SLOW_SOURCE: return $urandom_range(99) < 86;
            default:          return 1'b0;
        endcase
    endfunction

    // Slow rotation for half the items, the rest mostly jumps, a few out-of-range positions
    function automatic logic [POS_W-1:0] next_position();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            walk_pos = (walk_pos + CIRCLE_SPAN + $urandom_range(80) - 40) % CIRCLE_SPAN;
            return POS_W'(walk_pos);
        end
        else if (roll < 90)
        begin
            return POS_W'($urandom_range(CIRCLE_SPAN - 1));
        end
        return POS_W'($urandom_range((1 << POS_W) - 1, CIRCLE_SPAN));
    endfunction

    // Offer one position, predict on acceptance, then maybe idle
    task automatic send_position(input logic [POS_W-1:0] p, input logic pinned,
                                 input logic [SECTOR_W-1:0] sec,
                                 input logic [MASK_W-1:0] mask, input logic chg);
        pwm_frame_t f;
        in_valid <= 1'b1;
        position <= p;
        do @(posedge clk); while (!in_ready);
        f = commutate(p);
        if (pinned)
        begin
            f.sector         = sec;
            f.drive_positive = mask;
            f.sector_changed = chg;
        end
        pending_frames.push_back(f);
        items_sent++;
        traffic_mode <= (items_sent < 350) ? MODE_SLOW_SINK :
                        (items_sent < 700) ? MODE_SLOW_SOURCE : MODE_FULL_RATE;
        if (sender_pauses())
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (sender_pauses());
        end
    endtask

    // Stop offering items and wait for every outstanding result
    task automatic drain_results();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write amplitude then period, one per cycle
    task automatic load_gain(input logic [CFG_DATA_W-1:0] amp_data,
                             input logic [CFG_DATA_W-1:0] period_data);
        cfg_write <= 1'b1;
        cfg_index <= CFG_AMPLITUDE;
        cfg_data  <= amp_data;
        @(posedge clk);
        cfg_index <= CFG_PWM_PERIOD;
        cfg_data  <= period_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        amp_reg    = amp_data[AMP_W-1:0];
        period_reg = period_data;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Output side: random back-pressure per traffic mode
    always @(posedge clk)
    begin
        case (traffic_mode)
            MODE_SLOW_SINK:   out_ready <= $urandom_range(99) >= 86;
            MODE_SLOW_SOURCE: out_ready <= $urandom_range(99) >= 28;
            default:          out_ready <= 1'b1;
        endcase
    end

    // Compare each accepted result with the oldest expected frame
    always @(posedge clk)
    begin : check_results
        pwm_frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                         $time, "actual sector and widths", sector,
                         width_a, width_b, width_c);
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_checked++;
                check_field("width_a", want.width_a, width_a);
                check_field("width_b", want.width_b, width_b);
                check_field("width_c", want.width_c, width_c);
                check_field("drive_positive", want.drive_positive, drive_positive);
                check_field("sector_changed", want.sector_changed, sector_changed);
                check_field("sector", want.sector, sector);
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] amp_data;
        logic [CFG_DATA_W-1:0] period_data;
        int unsigned           quad;
        int unsigned           r;
        // Sine magnitudes from the first quadrant by symmetry; sign is dropped
        for (int i = 0; i < SECTOR_SPAN; i++)
        begin
            quad        = i / QUARTER_SPAN;
            r           = i % QUARTER_SPAN;
            sine_mag[i] = (quad % 2 == 1) ? quarter_wave(QUARTER_SPAN - r) : quarter_wave(r);
        end
        amp_reg     = AMP_RESET;
        period_reg  = PERIOD_RESET;
        prev_sector = 0;
        walk_pos    = $urandom_range(CIRCLE_SPAN - 1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_position(DIRECTED[i].pos, DIRECTED[i].pinned, DIRECTED[i].sec,
                          DIRECTED[i].mask, DIRECTED[i].chg);
        end

        // Random positions under a series of gain settings
        for (int ph = 0; ph < GAIN_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain_results();
                case (ph)
                    1:       begin amp_data = 16'd0;     period_data = 16'hFFFF; end
                    2:       begin amp_data = 16'h7FFF;  period_data = 16'hFFFF; end
                    3:       begin amp_data = 16'hFFFF;  period_data = 16'd1;    end // top bit dropped
                    4:       begin amp_data = 16'h7FFF;  period_data = 16'd2;    end // gain of one
                    5:       begin amp_data = 16'd16384; period_data = 16'd4;    end // gain equals bias
                    6:       begin amp_data = 16'd1;     period_data = 16'd0;    end // zero period
                    8:       begin amp_data = 16'd20000; period_data = 16'd1000; end
                    default:
                    begin
                        amp_data    = CFG_DATA_W'($urandom_range(32767));
                        period_data = CFG_DATA_W'($urandom_range(65535, 1));
                    end
                endcase
                load_gain(amp_data, period_data);
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // hold off mid-phase until the pipe is empty
                if (ph == 4 && k == RANDOM_PER_PHASE / 2)
                begin
                    drain_results();
                end
                send_position(next_position(), 1'b0, '0, '0, 1'b0);
            end
        end

        drain_results();
        $display("Sent %0d positions under %0d gain settings, out-of-range ones included.",
                 items_sent, GAIN_PHASES);
        $display("Checked %0d results, %0d sector changes, %0d field mismatches.",
                 frames_checked, sector_changes, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
